// ===== rtl/spnm_pkg.sv =====
// spnm_pkg: shared constants and types of the stereo pink noise mixer
// used by every module of the block except the generic ram and the divider

package spnm_pkg;

   localparam int MIX_W       = 17;
   localparam int RAND_W      = 16;
   localparam int RAND_FIELDS = 7;
   localparam int NOISE_W     = 16;

   localparam logic [MIX_W-1:0] MIX_RESET      = 17'd32768;
   // 0.001 in q1.16 rounds so that 66 is the first active level
   localparam logic [MIX_W-1:0] MIX_MIN_ACTIVE = 17'd66;

   // fill state of the front to back queue
   typedef struct packed {
      logic full;
      logic empty;
   } spnm_q_stat_type;

endpackage

// ===== rtl/spnm_ram.sv =====
// spnm_ram: generic single write port, single read port ram with registered read
// no dependencies

module spnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spnm_fifo.sv =====
// spnm_fifo: short flip-flop queue between the front and the back of the mixer
// depends on spnm_pkg for the queue status struct

module spnm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output spnm_pkg::spnm_q_stat_type  q_stat
);

   import spnm_pkg::*;

   localparam int PW = $clog2(DEPTH > 1 ? DEPTH : 2);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

`ifndef NO_ASSERTIONS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(wr_en && !rd_en && count_ff == CW'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      !(rd_en && count_ff == '0))
      else $error("queue read while empty");
`endif

endmodule

// ===== rtl/spnm_div.sv =====
// spnm_div: divides by a constant through a reciprocal multiply, quotient valid in the cycle after start
// depends on nothing; used by the back end for both rounded divisions

module spnm_div #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR    = 7
) (
   input  logic                  clock,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int LOG_D   = $clog2(DIVISOR);
   localparam int SHIFT   = DIVIDEND_W + LOG_D;
   localparam int RECIP_W = DIVIDEND_W + 1;
   localparam int PROD_W  = DIVIDEND_W + RECIP_W;
   // ceil(2^SHIFT / DIVISOR) gives the exact floor quotient for every dividend in range
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_W'(dividend) * PROD_W'(RECIP);
      end
   end

   assign quotient = DIVIDEND_W'(prod_ff >> SHIFT);

endmodule

// ===== rtl/spnm_front.sv =====
// spnm_front: accepts input beats, classifies them, advances the channel counter
// and updates the row registers; depends on spnm_pkg and spnm_ram

module spnm_front #(
   parameter int ROW_COUNT     = 7,
   parameter int CHANNEL_COUNT = 2,
   parameter int SAMPLE_BITS   = 16,
   localparam int ENTRY_W = 1 + SAMPLE_BITS + spnm_pkg::RAND_W * ROW_COUNT,
   localparam int IN_W    = SAMPLE_BITS + spnm_pkg::RAND_FIELDS * spnm_pkg::RAND_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [spnm_pkg::MIX_W-1:0]   mix,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_channel,
   input  logic [IN_W-1:0]              req_payload,
   output logic                         push,
   output logic [ENTRY_W-1:0]           push_data,
   input  spnm_pkg::spnm_q_stat_type    q_stat
);

   import spnm_pkg::*;

   localparam int ROW_W  = RAND_W * ROW_COUNT;
   localparam int ADDR_W = $clog2(CHANNEL_COUNT > 1 ? CHANNEL_COUNT : 2);

   typedef enum logic [1:0] {
      F_IDLE  = 2'b01,
      F_MERGE = 2'b10
   } front_state_type;

   front_state_type                 state_ff, state_in;
   logic [SAMPLE_BITS-1:0]          sample_ff;
   logic [RAND_FIELDS*RAND_W-1:0]   rand_ff;
   logic [ADDR_W-1:0]               addr_ff;
   logic                            active_ff;
   logic [ROW_COUNT-1:0]            cnt_ff [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0]        valid_ff;

   logic                            accept;
   logic                            in_range;
   logic                            active_now;
   logic [ADDR_W-1:0]               addr_now;
   logic [ROW_W-1:0]                rd_data;
   logic [ROW_W-1:0]                old_rows;
   logic [ROW_W-1:0]                new_rows;
   logic [ROW_COUNT-1:0]            cnt_old, cnt_new, toggled;
   logic                            ram_wr_en;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (int'(req_channel) < CHANNEL_COUNT);
   assign active_now = in_range && (mix >= MIX_MIN_ACTIVE);
   assign addr_now   = in_range ? ADDR_W'(req_channel) : '0;

   spnm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNEL_COUNT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (new_rows),
      .rd_en   (accept),
      .rd_addr (addr_now),
      .rd_data (rd_data)
   );

   assign cnt_old  = cnt_ff[addr_ff];
   assign cnt_new  = cnt_old + ROW_COUNT'(1);
   assign toggled  = cnt_old ^ cnt_new;
   // a channel never written reads as rows of zero, since the ram itself has no reset
   assign old_rows = valid_ff[addr_ff] ? rd_data : '0;

   for (genvar i = 0; i < ROW_COUNT; i++) begin : g_row
      if (i < RAND_FIELDS) begin : g_rand
         assign new_rows[i*RAND_W +: RAND_W] = toggled[i] ? rand_ff[i*RAND_W +: RAND_W]
                                                          : old_rows[i*RAND_W +: RAND_W];
      end else begin : g_zero
         assign new_rows[i*RAND_W +: RAND_W] = toggled[i] ? '0 : old_rows[i*RAND_W +: RAND_W];
      end
   end

   assign push      = (state_ff == F_MERGE) && !q_stat.full;
   assign ram_wr_en = push && active_ff;
   assign push_data = {active_ff, sample_ff, new_rows};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_MERGE;
            end
         end
         F_MERGE: begin
            if (!q_stat.full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         valid_ff <= '0;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            cnt_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (ram_wr_en) begin
            cnt_ff[addr_ff]   <= cnt_new;
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_payload[SAMPLE_BITS-1:0];
         rand_ff   <= req_payload[IN_W-1:SAMPLE_BITS];
         addr_ff   <= addr_now;
         active_ff <= active_now;
      end
   end

`ifndef NO_ASSERTIONS
   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (int'(addr_ff) < CHANNEL_COUNT) && (state_ff == F_MERGE))
      else $error("row write outside a generator channel");
`endif

endmodule

// ===== rtl/spnm_back.sv =====
// spnm_back: sums the rows, scales the noise, runs both rounded divisions,
// saturates and holds the result beat; depends on spnm_pkg and spnm_div

module spnm_back #(
   parameter int ROW_COUNT   = 7,
   parameter int SAMPLE_BITS = 16,
   localparam int ENTRY_W = 1 + SAMPLE_BITS + spnm_pkg::RAND_W * ROW_COUNT,
   localparam int RSP_W   = ((SAMPLE_BITS + spnm_pkg::NOISE_W + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [spnm_pkg::MIX_W-1:0]   mix,
   input  logic [ENTRY_W-1:0]           q_data,
   input  spnm_pkg::spnm_q_stat_type    q_stat,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_W-1:0]             rsp_tdata
);

   import spnm_pkg::*;

   localparam int ROW_W   = RAND_W * ROW_COUNT;
   localparam int SUM_W   = RAND_W + $clog2(ROW_COUNT);
   localparam int PROD_W  = SUM_W + MIX_W;
   localparam int P3_W    = PROD_W + 2;
   localparam int SHIFT   = 32 - SAMPLE_BITS;
   localparam int NUM_W   = P3_W - SHIFT + 1;
   localparam int NDIV_W  = SUM_W + 1;
   localparam int HALF_R  = ROW_COUNT / 2;
   localparam int ROUND_A = 10 * ROW_COUNT;
   localparam int SUMO_W  = (SAMPLE_BITS > NUM_W ? SAMPLE_BITS : NUM_W) + 2;
   localparam int CNT_W   = $clog2(ROW_COUNT);
   localparam int OUT_W   = SAMPLE_BITS + NOISE_W;

   typedef enum logic [6:0] {
      B_IDLE  = 7'b0000001,
      B_SUM   = 7'b0000010,
      B_ABS   = 7'b0000100,
      B_MUL   = 7'b0001000,
      B_SCALE = 7'b0010000,
      B_WAIT  = 7'b0100000,
      B_DONE  = 7'b1000000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic                    rsp_valid_ff;
   logic [OUT_W-1:0]        rsp_data_ff;
   logic [SAMPLE_BITS-1:0]  sample_ff;
   logic [ROW_W-1:0]        rows_ff;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    neg_ff;
   logic [SUM_W-1:0]        mag_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [SAMPLE_BITS-1:0]  res_ff, res_in;
   logic [NOISE_W-1:0]      noise_ff, noise_in;

   logic                    q_active;
   logic [SAMPLE_BITS-1:0]  q_sample;
   logic [ROW_W-1:0]        q_rows;
   logic                    load_out;
   logic [NDIV_W-1:0]       n_quo, n_signed;
   logic [NUM_W-1:0]        a_quo;
   logic [P3_W-1:0]         p3;
   logic [NUM_W-1:0]        a_num;
   logic [SUMO_W-1:0]       s_ext, q_ext, total;
   logic [SUMO_W-SAMPLE_BITS:0] top_bits;

   assign q_active = q_data[ENTRY_W-1];
   assign q_sample = q_data[ENTRY_W-2 -: SAMPLE_BITS];
   assign q_rows   = q_data[ROW_W-1:0];

   assign pop      = (state_ff == B_IDLE) && !q_stat.empty;
   assign load_out = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_tready);

   // row accumulation, one row a cycle
   assign acc_in = acc_ff + {{(SUM_W-RAND_W){rows_ff[RAND_W-1]}}, rows_ff[RAND_W-1:0]};

   // noise * mix * 3/20 / rows: the 2^16 scale and half of 20*rows fold into the numerator
   assign p3    = P3_W'(prod_ff) + (P3_W'(prod_ff) << 1);
   assign a_num = NUM_W'(p3 >> SHIFT) + NUM_W'(ROUND_A);

   spnm_div #(
      .DIVIDEND_W (NDIV_W),
      .DIVISOR    (ROW_COUNT)
   ) u_noise_div (
      .clock    (clock),
      .start    (state_ff == B_MUL),
      .dividend (NDIV_W'(mag_ff) + NDIV_W'(HALF_R)),
      .quotient (n_quo)
   );

   spnm_div #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR    (20 * ROW_COUNT)
   ) u_add_div (
      .clock    (clock),
      .start    (state_ff == B_SCALE),
      .dividend (a_num),
      .quotient (a_quo)
   );

   assign n_signed = neg_ff ? (~n_quo + NDIV_W'(1)) : n_quo;
   assign noise_in = n_signed[NOISE_W-1:0];

   assign s_ext    = {{(SUMO_W-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
   assign q_ext    = SUMO_W'(a_quo);
   assign total    = neg_ff ? (s_ext - q_ext) : (s_ext + q_ext);
   assign top_bits = total[SUMO_W-1:SAMPLE_BITS-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         res_in = total[SAMPLE_BITS-1:0];
      end else if (total[SUMO_W-1]) begin
         res_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               state_in = q_active ? B_SUM : B_DONE;
            end
         end
         B_SUM: begin
            if (cnt_ff == CNT_W'(ROW_COUNT - 1)) begin
               state_in = B_ABS;
            end
         end
         B_ABS:   state_in = B_MUL;
         B_MUL:   state_in = B_SCALE;
         B_SCALE: state_in = B_WAIT;
         B_WAIT:  state_in = B_DONE;
         B_DONE: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            // a bypassed beat leaves straight from here with zero noise
            sample_ff <= q_sample;
            rows_ff   <= q_rows;
            acc_ff    <= '0;
            cnt_ff    <= '0;
            res_ff    <= q_sample;
            noise_ff  <= '0;
         end
         B_SUM: begin
            acc_ff  <= acc_in;
            rows_ff <= rows_ff >> RAND_W;
            cnt_ff  <= cnt_ff + CNT_W'(1);
         end
         B_ABS: begin
            neg_ff <= acc_ff[SUM_W-1];
            mag_ff <= acc_ff[SUM_W-1] ? (~acc_ff + SUM_W'(1)) : acc_ff;
         end
         B_MUL: begin
            prod_ff <= PROD_W'(mag_ff) * PROD_W'(mix);
         end
         B_WAIT: begin
            res_ff   <= res_in;
            noise_ff <= noise_in;
         end
         default: ;
      endcase
      if (load_out) begin
         rsp_data_ff <= {noise_ff, res_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

`ifndef NO_ASSERTIONS
   // the rounded row mean can never leave the q1.15 range
   a_noise_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WAIT) |-> n_quo <= NDIV_W'(32768))
      else $error("noise quotient out of range");
`endif

endmodule

// ===== rtl/stereo_pink_noise_mixer.sv =====
// Adds seven-row pink noise to a stereo sample stream; one result beat per request beat.
//
// req channel: tuser carries the channel (0 left, 1 right); tdata carries the sample
// and seven random row values. rsp channel: tdata carries the mixed sample and the
// noise value. csr_wr_en with csr_wr_data loads the 17-bit mix level (q1.16); write it
// only while no beat is in flight.
// The front takes one beat at a time: it reads the channel's rows from a small ram,
// updates counter and rows for a beat with noise, and hands the beat to a 2-entry
// queue before it takes the next. The back sums the rows one per cycle, then scales
// and divides by constants with reciprocal multiplies. A beat without noise (mix
// below 66 or no generator for its channel) skips the row sum and the divisions.
// Reset returns the mix level to 0.5, clears all counters and marks every channel's
// rows as zero. A stalled rsp_tready holds the result register; the queue then fills
// and req_tready drops until the result is taken. Rows and results are never lost.
// Depends on spnm_pkg, spnm_front, spnm_fifo, spnm_back, spnm_div and spnm_ram.

module stereo_pink_noise_mixer #(
   parameter int ROW_COUNT     = 7,
   parameter int CHANNEL_COUNT = 2,
   parameter int SAMPLE_BITS   = 16,
   localparam int IN_W  = SAMPLE_BITS + spnm_pkg::RAND_FIELDS * spnm_pkg::RAND_W,
   localparam int REQ_W = ((IN_W + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + spnm_pkg::NOISE_W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [spnm_pkg::MIX_W-1:0] csr_wr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_tuser,   // channel
   input  logic [REQ_W-1:0]           req_tdata,   // sample_in, rand_row_0 .. rand_row_6
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata    // sample_out, noise_value
);

   import spnm_pkg::*;

   localparam int ENTRY_W = 1 + SAMPLE_BITS + RAND_W * ROW_COUNT;

   logic [MIX_W-1:0]    mix_ff;
   logic                push;
   logic                pop;
   logic [ENTRY_W-1:0]  push_data;
   logic [ENTRY_W-1:0]  q_data;
   spnm_q_stat_type     q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff <= MIX_RESET;
      end else if (csr_wr_en) begin
         mix_ff <= csr_wr_data;
      end
   end

   spnm_front #(
      .ROW_COUNT     (ROW_COUNT),
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .mix         (mix_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_channel (req_tuser),
      .req_payload (req_tdata[IN_W-1:0]),
      .push        (push),
      .push_data   (push_data),
      .q_stat      (q_stat)
   );

   spnm_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_data),
      .rd_en   (pop),
      .rd_data (q_data),
      .q_stat  (q_stat)
   );

   spnm_back #(
      .ROW_COUNT   (ROW_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mix        (mix_ff),
      .q_data     (q_data),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
